[rtl/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 decoder: result codes, DFA state codes,
// the byte class map, the transition table and the shared record types.
// No dependencies.
package u8u16_pkg;

   localparam int unsigned MAX_RES    = 3;
   localparam int unsigned NUM_STATES = 9;
   localparam int unsigned NUM_CLASS  = 12;

   // result kinds
   localparam logic [1:0] KIND_UNIT      = 2'd0;
   localparam logic [1:0] KIND_COMPLETE  = 2'd1;
   localparam logic [1:0] KIND_INVALID   = 2'd2;
   localparam logic [1:0] KIND_TRUNCATED = 2'd3;

   // automaton states with a meaning of their own
   localparam logic [3:0] ST_ACCEPT = 4'd0;
   localparam logic [3:0] ST_REJECT = 4'd1;

   localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

   localparam logic [3:0] NEXT_STATE [NUM_STATES][NUM_CLASS] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
   };

   typedef struct packed {
      logic [3:0]  dfa;
      logic [20:0] acc;
      logic        discarding;
   } dec_state_type;

   // all results caused by one input item
   typedef struct packed {
      logic [1:0]                 count;
      logic [MAX_RES-1:0][1:0]    kind;
      logic [MAX_RES-1:0][15:0]   unit;
   } res_rec_type;

   function automatic logic [3:0] byte_class(input logic [7:0] b);
      logic [3:0] cls;
      if (b < 8'h80)       cls = 4'd0;
      else if (b < 8'h90)  cls = 4'd1;
      else if (b < 8'hA0)  cls = 4'd9;
      else if (b < 8'hC0)  cls = 4'd7;
      else if (b < 8'hC2)  cls = 4'd8;
      else if (b < 8'hE0)  cls = 4'd2;
      else if (b == 8'hE0) cls = 4'd10;
      else if (b == 8'hED) cls = 4'd4;
      else if (b < 8'hF0)  cls = 4'd3;
      else if (b == 8'hF0) cls = 4'd11;
      else if (b < 8'hF4)  cls = 4'd6;
      else if (b == 8'hF4) cls = 4'd5;
      else                 cls = 4'd8;
      return cls;
   endfunction

   function automatic logic [3:0] next_dfa(input logic [3:0] st, input logic [3:0] cls);
      logic [3:0] nxt;
      if (st >= 4'(NUM_STATES) || cls >= 4'(NUM_CLASS)) nxt = ST_REJECT;
      else nxt = NEXT_STATE[st][cls];
      return nxt;
   endfunction

endpackage

[rtl/u8u16_req_if.sv]
// Input channel of the decoder: one UTF-8 byte and its end flag per item.
// No dependencies.
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

[rtl/u8u16_rsp_if.sv]
// Result channel of the decoder: one result kind, code unit and run flag per item.
// No dependencies.
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] code_unit;
   logic        last_of_run;

   modport source (output valid, output result_kind, output code_unit, output last_of_run,
                   input ready);
   modport sink   (input valid, input result_kind, input code_unit, input last_of_run,
                   output ready);
endinterface

[rtl/u8u16_step.sv]
// One decoder step: byte class, DFA transition, accumulator update and the
// record of up to three results. Pure logic. Depends on u8u16_pkg.
module u8u16_step (
   input  u8u16_pkg::dec_state_type cur,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_string,
   output u8u16_pkg::dec_state_type nxt,
   output u8u16_pkg::res_rec_type   rec
);
   import u8u16_pkg::*;

   logic [3:0]  cls;
   logic [7:0]  lead_mask;
   logic [20:0] acc_new;
   logic [3:0]  dfa_new;

   always_comb begin
      cls       = byte_class(data_byte);
      lead_mask = 8'hFF >> cls;
      if (cur.dfa != ST_ACCEPT) acc_new = {cur.acc[14:0], data_byte[5:0]};
      else acc_new = {13'd0, lead_mask & data_byte};
      dfa_new = next_dfa(cur.dfa, cls);
   end

   always_comb begin
      nxt = cur;
      rec = '0;
      if (cur.discarding) begin
         // error already reported: drop bytes until the end flag
         if (end_of_string) nxt = '0;
      end else begin
         nxt.acc = acc_new;
         nxt.dfa = dfa_new;
         if (dfa_new == ST_REJECT) begin
            rec.count   = 2'd1;
            rec.kind[0] = KIND_INVALID;
            if (end_of_string) nxt = '0;
            else nxt.discarding = 1'b1;
         end else if (dfa_new == ST_ACCEPT) begin
            if (acc_new[20:16] == 5'd0) begin
               rec.count   = 2'd1;
               rec.unit[0] = acc_new[15:0];
            end else begin
               rec.count   = 2'd2;
               rec.unit[0] = HI_SURR_BASE + {5'd0, acc_new[20:10]};
               rec.unit[1] = LO_SURR_BASE + {6'd0, acc_new[9:0]};
            end
            rec.kind[0] = KIND_UNIT;
            rec.kind[1] = KIND_UNIT;
            if (end_of_string) begin
               rec.kind[rec.count] = KIND_COMPLETE;
               rec.count           = rec.count + 2'd1;
               nxt                 = '0;
            end
         end else if (end_of_string) begin
            rec.count   = 2'd1;
            rec.kind[0] = KIND_TRUNCATED;
            nxt         = '0;
         end
      end
   end

endmodule

[rtl/utf8_to_utf16_decoder_core.sv]
// Top level of the UTF-8 to UTF-16 decoder: decoder state registers, the step
// logic and a two-record result queue. Depends on u8u16_pkg, u8u16_step and
// the u8u16_req_if / u8u16_rsp_if interfaces.
//
//   channel | dir | payload                                  | accepted when
//   req     | in  | data_byte[7:0], end_of_string            | req.valid && req.ready
//   rsp     | out | result_kind[1:0], code_unit[15:0],       | rsp.valid && rsp.ready
//           |     | last_of_run                              |
//
// A byte is decoded in the cycle it is accepted; its results sit in the queue
// from the next cycle and leave one per cycle while rsp.ready is high. Bytes giving
// at most one result flow at one per cycle while rsp.ready is high; a surrogate pair
// or a completion leaves one result at a time through the single result port.
// req.ready drops only while both queue records are held and the head is not
// leaving. Reset is synchronous, active high, and empties the queue.
module utf8_to_utf16_decoder_core (
   input  logic         clock,
   input  logic         reset,
   u8u16_req_if.sink    req,
   u8u16_rsp_if.source  rsp
);
   import u8u16_pkg::*;

   dec_state_type st_ff, st_in;
   res_rec_type   step_rec;
   res_rec_type   rec_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;
   logic [1:0]    idx_ff;
   res_rec_type   head;
   logic          push, pop, req_take, rsp_take, head_last;

   u8u16_step u_step (
      .cur           (st_ff),
      .data_byte     (req.data_byte),
      .end_of_string (req.end_of_string),
      .nxt           (st_in),
      .rec           (step_rec)
   );

   always_comb begin
      head      = rec_ff[rd_ptr_ff];
      head_last = (idx_ff == head.count - 2'd1);
      rsp_take  = rsp.valid && rsp.ready;
      pop       = rsp_take && head_last;
      req.ready = (count_ff != 2'd2) || pop;
      req_take  = req.valid && req.ready;
      push      = req_take && (step_rec.count != 2'd0);
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rsp.valid       = (count_ff != 2'd0);
   assign rsp.result_kind = head.kind[idx_ff];
   assign rsp.code_unit   = head.unit[idx_ff];
   assign rsp.last_of_run = head_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         idx_ff    <= 2'd0;
      end else begin
         if (req_take) st_ff <= st_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
         // advance within the head record, restart at the next one
         if (pop) idx_ff <= 2'd0;
         else if (rsp_take) idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) rec_ff[wr_ptr_ff] <= step_rec;
   end

endmodule
